FILE: src/ols_pkg.sv
// Shared types and constants for the ordered list store.
// Holds operation and status codes and the controller/datapath command bundles.
// No dependencies.
`timescale 1ns / 1ps

package ols_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int ST_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DELETE    = 3'd3,
    OP_DUMP      = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VALUE
  } wr_mode_t;

  typedef struct packed {
    logic     load;
    logic     ptr_clr;
    logic     ptr_ld_cnt;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd_en;
    logic     rd_prev;
    wr_mode_t wr_mode;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     emit;
    status_t  emit_status;
    logic     emit_has;
    logic     emit_last;
  } ols_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_zero;
    logic pos_range;
    logic full;
    logic cnt_zero;
    logic at_idx;
    logic p_end;
    logic rd_v;
    logic rd_last;
    logic match;
  } ols_stat_t;

endpackage

FILE: src/ordered_list_store_top.sv
// Top level of the ordered list store: a bounded ordered list of signed words.
// Depends on ols_pkg, ols_ctrl and ols_dpath (which holds the ols_ram entry store).
`timescale 1ns / 1ps

// Usage
// An input beat (in_operation, in_value, in_position) is taken at a rising edge
// where start is high and busy is low. Operations are insert at front, insert at
// back, insert at a 1-based position, delete the first entry equal to a key, and
// dump. Every operation gives one result beat, except a dump of a non-empty list,
// which gives one beat per entry in front-to-back order on consecutive cycles.
// A result beat is shown for exactly one cycle with out_valid high; out_last
// marks the final beat of an item. The receiver cannot stall the block, so there
// is no backpressure and no result is ever held.
// Timing: the entries live in a RAM with one write and one registered read port,
// and every shift, search and dump walks that RAM one entry per cycle. An item
// rejected at decode gets its result from the decode state. An insert walks from
// the tail down to its slot; a delete or a dump walks the whole list. One item
// is worked at a time; busy stays high from the accept until the last result is
// issued, and a new item may be accepted in the same cycle that result is on
// the ports.
// Reset (rst_n low, synchronous) empties the list and drops busy and out_valid;
// the RAM contents are not cleared, since entries past the length are never read.

module ordered_list_store_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ols_pkg::OP_W-1:0]          in_operation,
  input  logic signed [ols_pkg::DATA_W-1:0] in_value,
  input  logic [ols_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [ols_pkg::ST_W-1:0]          out_status,
  output logic                              out_has_value,
  output logic signed [ols_pkg::DATA_W-1:0] out_entry_value,
  output logic [ols_pkg::LEN_W-1:0]         out_length,
  output logic                              out_last
);

  import ols_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  ols_cmd_t  cmd;
  ols_stat_t stat;

  ols_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  // The datapath registers every result, so the result ports come straight
  // from flops.
  ols_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_position    (in_position),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_has_value  (out_has_value),
    .out_entry_value(out_entry_value),
    .out_length     (out_length),
    .out_last       (out_last)
  );

endmodule

FILE: src/ols_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ols_dpath.sv
// Datapath of the ordered list store: item registers, entry count, walk pointer,
// entry RAM and the result registers. Depends on ols_pkg and ols_ram.
`timescale 1ns / 1ps

module ols_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ols_pkg::OP_W-1:0]         in_operation,
  input  logic signed [ols_pkg::DATA_W-1:0] in_value,
  input  logic [ols_pkg::POS_W-1:0]        in_position,
  input  ols_pkg::ols_cmd_t                cmd,
  output ols_pkg::ols_stat_t               stat,
  output logic                             out_valid,
  output logic [ols_pkg::ST_W-1:0]         out_status,
  output logic                             out_has_value,
  output logic signed [ols_pkg::DATA_W-1:0] out_entry_value,
  output logic [ols_pkg::LEN_W-1:0]        out_length,
  output logic                             out_last
);

  import ols_pkg::*;

  op_t               op_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic              rd_v_r;
  logic [ADDR_W-1:0] last_rd_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_has_r;
  logic [DATA_W-1:0] out_value_r;
  logic [LEN_W-1:0]  out_length_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  idx_w;
  logic [CNT_W-1:0]  p_prev_w;
  logic [ADDR_W-1:0] raddr_w;
  logic [ADDR_W-1:0] waddr_w;
  logic [DATA_W-1:0] wdata_w;
  logic              we_w;
  logic [DATA_W-1:0] rdata_w;
  logic [LEN_W-1:0]  pos_ext_w;
  logic [LEN_W-1:0]  cnt_ext_w;
  logic [CNT_W-1:0]  last_rd_ext_w;

  assign pos_ext_w     = LEN_W'(pos_r);
  assign cnt_ext_w     = LEN_W'(cnt_r);
  assign last_rd_ext_w = CNT_W'(last_rd_r);
  assign p_prev_w      = p_r - CNT_W'(1);

  // Insert slot: front, back, or the 1-based position turned 0-based.
  always_comb begin
    case (op_r)
      OP_INS_FRONT: idx_w = '0;
      OP_INS_BACK:  idx_w = cnt_r;
      default:      idx_w = CNT_W'(pos_ext_w - LEN_W'(1));
    endcase
  end

  assign raddr_w = cmd.rd_prev ? p_prev_w[ADDR_W-1:0] : p_r[ADDR_W-1:0];

  always_comb begin
    case (cmd.wr_mode)
      WR_UP: begin
        waddr_w = last_rd_r + ADDR_W'(1);
        wdata_w = rdata_w;
      end
      WR_DOWN: begin
        waddr_w = last_rd_r - ADDR_W'(1);
        wdata_w = rdata_w;
      end
      WR_VALUE: begin
        waddr_w = idx_w[ADDR_W-1:0];
        wdata_w = val_r;
      end
      default: begin
        waddr_w = last_rd_r;
        wdata_w = rdata_w;
      end
    endcase
  end

  assign we_w = (cmd.wr_mode != WR_NONE);

  ols_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we_w),
    .waddr(waddr_w),
    .wdata(wdata_w),
    .re   (cmd.rd_en),
    .raddr(raddr_w),
    .rdata(rdata_w)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    p_nxt = p_r;
    if (cmd.ptr_clr) begin
      p_nxt = '0;
    end else if (cmd.ptr_ld_cnt) begin
      p_nxt = cnt_r;
    end else if (cmd.ptr_inc) begin
      p_nxt = p_r + CNT_W'(1);
    end else if (cmd.ptr_dec) begin
      p_nxt = p_prev_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_v_r      <= cmd.rd_en;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.rd_en) begin
      last_rd_r <= raddr_w;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_has_r    <= cmd.emit_has;
      out_value_r  <= cmd.emit_has ? rdata_w : '0;
      out_length_r <= LEN_W'(cnt_nxt);
      out_last_r   <= cmd.emit_last;
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.pos_zero  = (pos_r == '0);
    stat.pos_range = (pos_ext_w > cnt_ext_w + LEN_W'(1));
    stat.full      = (cnt_ext_w == LEN_W'(CAPACITY));
    stat.cnt_zero  = (cnt_r == '0);
    stat.at_idx    = (p_r == idx_w);
    stat.p_end     = (p_r == cnt_r);
    stat.rd_v      = rd_v_r;
    stat.rd_last   = rd_v_r && (last_rd_ext_w + CNT_W'(1) == cnt_r);
    stat.match     = (rdata_w == val_r);
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_has_value   = out_has_r;
  assign out_entry_value = out_value_r;
  assign out_length      = out_length_r;
  assign out_last        = out_last_r;

endmodule

FILE: src/ols_ctrl.sv
// Controller of the ordered list store: sequences decode, shift, search and dump.
// Depends on ols_pkg.
`timescale 1ns / 1ps

module ols_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ols_pkg::ols_stat_t stat,
  output ols_pkg::ols_cmd_t  cmd
);

  import ols_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_FILL,
    S_DEL_SCAN,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;

  always_comb begin
    cmd             = '0;
    cmd.wr_mode     = WR_NONE;
    cmd.emit_status = ST_OK;
    state_nxt       = state_r;
    found_nxt       = found_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (stat.op)
          OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (stat.op == OP_INS_POS && stat.pos_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_BAD_POS;
              state_nxt       = S_IDLE;
            end else if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_FULL;
              state_nxt       = S_IDLE;
            end else if (stat.op == OP_INS_POS && stat.pos_range) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.ptr_ld_cnt = 1'b1;
              state_nxt      = S_INS_SHIFT;
            end
          end
          OP_DELETE: begin
            if (stat.cnt_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_NOT_FOUND;
              state_nxt       = S_IDLE;
            end else begin
              cmd.ptr_clr = 1'b1;
              found_nxt   = 1'b0;
              state_nxt   = S_DEL_SCAN;
            end
          end
          OP_DUMP: begin
            if (stat.cnt_zero) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              cmd.ptr_clr = 1'b1;
              state_nxt   = S_DUMP;
            end
          end
          default: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      // Walk down from the tail, moving each entry one slot up.
      S_INS_SHIFT: begin
        if (stat.rd_v) begin
          cmd.wr_mode = WR_UP;
        end
        if (!stat.at_idx) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          cmd.ptr_dec = 1'b1;
        end else begin
          state_nxt = S_INS_FILL;
        end
      end

      S_INS_FILL: begin
        if (stat.rd_v) begin
          cmd.wr_mode = WR_UP;
        end else begin
          cmd.wr_mode   = WR_VALUE;
          cmd.cnt_inc   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Search front to back; once the key is found, later entries move down.
      S_DEL_SCAN: begin
        if (!stat.p_end) begin
          cmd.rd_en   = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
        if (stat.rd_v) begin
          if (found_r) begin
            cmd.wr_mode = WR_DOWN;
          end else if (stat.match) begin
            found_nxt = 1'b1;
          end
        end
        if (stat.rd_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (found_r || stat.match) begin
            cmd.cnt_dec = 1'b1;
          end else begin
            cmd.emit_status = ST_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end
      end

      S_DUMP: begin
        if (!stat.p_end) begin
          cmd.rd_en   = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
        if (stat.rd_v) begin
          cmd.emit      = 1'b1;
          cmd.emit_has  = 1'b1;
          cmd.emit_last = stat.rd_last;
        end
        if (stat.rd_last) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: src/ols_checker.sv
// Port-level checker for the ordered list store, bound to the top level.
// Depends on ols_pkg and ordered_list_store_top.
`timescale 1ns / 1ps

module ols_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [ols_pkg::ST_W-1:0]          out_status,
  input logic                              out_has_value,
  input logic [ols_pkg::LEN_W-1:0]         out_length,
  input logic                              out_last
);

  import ols_pkg::*;

  // An accepted item always occupies the block, so busy goes high.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted beat");

  // A dump run carries on without gaps until its last beat.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a multi-beat result run");

  // Only dump beats come without last, and those carry an entry with ok status.
  a_run_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_has_value && (out_status == ST_OK))
    else $error("non-final beat without an entry or with bad status");

  // A beat that carries no entry ends its item.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |-> out_last)
    else $error("beat without entry is not the last of its item");

  // The reported length never exceeds the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= LEN_W'(CAPACITY)))
    else $error("reported length beyond capacity");

endmodule

bind ordered_list_store_top ols_checker u_ols_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the ordered list store: a directed table, then random items.
// Results are checked beat by beat against a list predictor kept in this file.
// Depends on ols_pkg and ordered_list_store_top.
`timescale 1ns / 1ps

module testbench;
  import ols_pkg::*;

  // Operation codes 5 to 7 are not defined by the package; the block answers them with a plain ok beat.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int RAND_ITEMS   = 340;
  localparam int SETTLE_CYCLS = 40;
  localparam int MAX_REPORTS  = 200;

  // One result beat as it should appear on the out_ ports.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              has_value;
    logic [DATA_W-1:0] entry_value;
    logic [LEN_W-1:0]  length;
    logic              last;
  } list_beat_t;

  // One row of the directed table. A row with fixed set carries its single
  // result beat typed in; every other row is checked against the predictor.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic [4:0]        reps;
    logic              fixed;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;
  } dir_row_t;

  localparam int N_DIR = 19;

  // The list starts empty. The early rows hit each rejection on an empty list,
  // build a short list with every insert form, then a repeated back insert fills
  // the list with duplicates so that the full cases and a duplicate delete can be
  // tried. Expected list contents are noted where they help.
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_DUMP,      32'h0000_0000,  6'd0, 5'd1,  1'b1, ST_OK,        7'd0},
    '{OP_DELETE,    32'h0000_0005,  6'd0, 5'd1,  1'b1, ST_NOT_FOUND, 7'd0},
    '{OP_INS_POS,   32'h0000_0009,  6'd0, 5'd1,  1'b1, ST_BAD_POS,   7'd0},
    '{OP_INS_POS,   32'h0000_0009, 6'd63, 5'd1,  1'b1, ST_RANGE,     7'd0},
    // Position one on an empty list must insert.
    '{OP_INS_POS,   32'h7FFF_FFFF,  6'd1, 5'd1,  1'b1, ST_OK,        7'd1},
    '{OP_INS_FRONT, 32'h8000_0000,  6'd0, 5'd1,  1'b1, ST_OK,        7'd2},
    '{OP_INS_BACK,  32'hFFFF_FFFF,  6'd0, 5'd1,  1'b1, ST_OK,        7'd3},
    // Position length+1 appends.
    '{OP_INS_POS,   32'h5555_5555,  6'd4, 5'd1,  1'b1, ST_OK,        7'd4},
    '{OP_INS_POS,   32'hAAAA_AAAA,  6'd2, 5'd1,  1'b1, ST_OK,        7'd5},
    '{OP_DUMP,      32'h0000_0000,  6'd0, 5'd1,  1'b0, ST_OK,        7'd0},
    '{OP_UNUSED_HI, 32'hFFFF_FFFF, 6'd63, 5'd1,  1'b1, ST_OK,        7'd5},
    '{OP_UNUSED_LO, 32'h0000_0000,  6'd0, 5'd1,  1'b1, ST_OK,        7'd5},
    // Remove the front entry, leaving four, then fill with duplicates.
    '{OP_DELETE,    32'h8000_0000,  6'd0, 5'd1,  1'b1, ST_OK,        7'd4},
    '{OP_INS_BACK,  32'h0000_1234,  6'd0, 5'd12, 1'b0, ST_OK,        7'd0},
    '{OP_INS_FRONT, 32'h0000_0001,  6'd0, 5'd1,  1'b1, ST_FULL,      7'd16},
    // On a full list a zero position is still reported as invalid position,
    // while a position past the end is reported as full.
    '{OP_INS_POS,   32'h0000_0002,  6'd0, 5'd1,  1'b1, ST_BAD_POS,   7'd16},
    '{OP_INS_POS,   32'h0000_0003, 6'd17, 5'd1,  1'b1, ST_FULL,      7'd16},
    '{OP_DUMP,      32'h0000_0000,  6'd0, 5'd1,  1'b0, ST_OK,        7'd0},
    '{OP_DELETE,    32'h0000_1234,  6'd0, 5'd1,  1'b1, ST_OK,        7'd15}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          in_operation;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic [ST_W-1:0]          out_status;
  logic                     out_has_value;
  logic signed [DATA_W-1:0] out_entry_value;
  logic [LEN_W-1:0]         out_length;
  logic                     out_last;

  // Predicted list contents, front first, as of the last accepted beat.
  logic [DATA_W-1:0] list_entries [$];
  // Beats predicted for the item just accepted.
  list_beat_t        op_beats [$];
  // Beats still owed by the block, oldest first.
  list_beat_t        expected_beats [$];
  int                mismatch_count;

  ordered_list_store_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_has_value   (out_has_value),
    .out_entry_value (out_entry_value),
    .out_length      (out_length),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never delivers an owed beat.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
  endtask

  // Applies one item to the predicted list and leaves its result beats in op_beats.
  // Rejected inserts and deletes leave the list alone; unknown codes only report
  // the current length.
  function automatic void apply_list_op(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] val,
                                        input logic [POS_W-1:0] pos);
    int              len;
    int              idx;
    logic [ST_W-1:0] st;
    len = list_entries.size();
    op_beats.delete();
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (op == OP_INS_POS && pos == 0) begin
          st = ST_BAD_POS;
        end else if (len >= CAPACITY) begin
          st = ST_FULL;
        end else if (op == OP_INS_POS && pos > len + 1) begin
          st = ST_RANGE;
        end else begin
          if (op == OP_INS_FRONT) idx = 0;
          else if (op == OP_INS_BACK) idx = len;
          else idx = pos - 1;
          list_entries.insert(idx, val);
          st = ST_OK;
        end
        op_beats.push_back('{st, 1'b0, '0, LEN_W'(list_entries.size()), 1'b1});
      end
      OP_DELETE: begin
        idx = -1;
        for (int i = 0; i < len; i++) begin
          if (idx < 0 && list_entries[i] == val) idx = i;
        end
        if (idx >= 0) begin
          list_entries.delete(idx);
          st = ST_OK;
        end else begin
          st = ST_NOT_FOUND;
        end
        op_beats.push_back('{st, 1'b0, '0, LEN_W'(list_entries.size()), 1'b1});
      end
      OP_DUMP: begin
        if (len == 0) begin
          op_beats.push_back('{ST_OK, 1'b0, '0, LEN_W'(0), 1'b1});
        end else begin
          for (int i = 0; i < len; i++) begin
            op_beats.push_back('{ST_OK, 1'b1, list_entries[i], LEN_W'(len),
                                 (i == len - 1)});
          end
        end
      end
      default: begin
        op_beats.push_back('{ST_OK, 1'b0, '0, LEN_W'(len), 1'b1});
      end
    endcase
  endfunction

  // Presents one beat and holds it until the block takes it. The predictor runs
  // here, at the accepting edge, so the stimulus code below always sees the list
  // as it stands after the item. A fixed row replaces the predicted beat with the
  // one typed into the table.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos, input logic fixed,
                           input logic [ST_W-1:0] fix_status,
                           input logic [LEN_W-1:0] fix_length);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    apply_list_op(op, val, pos);
    if (fixed) begin
      expected_beats.push_back('{fix_status, 1'b0, '0, fix_length, 1'b1});
    end else begin
      foreach (op_beats[i]) expected_beats.push_back(op_beats[i]);
    end
  endtask

  // Random pause between beats: mostly none or short, now and then long. While
  // start is low the payload ports carry noise that the block must ignore.
  task automatic idle_gap(input bit quiet);
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start        <= 1'b0;
      in_operation <= OP_W'($urandom);
      in_value     <= $urandom;
      in_position  <= POS_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the sender off until every owed beat has come back.
  task automatic drain_wait();
    start <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  // Values lean toward a handful of small numbers so that deletes meet duplicates,
  // with the signed extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 85) return $urandom_range(0, 7) - 4;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Builds one random item. Most inserts use a legal position and most deletes a
  // key that is in the list, so the shifts and searches run over real contents;
  // the rest are out-of-range positions, absent keys and unknown codes. In fill
  // mode inserts dominate so that the list often runs full; otherwise deletes
  // dominate and the list often drains empty.
  task automatic pick_item(input bit fill_mode, output logic [OP_W-1:0] op,
                           output logic [DATA_W-1:0] val,
                           output logic [POS_W-1:0] pos);
    int len;
    int r;
    len = list_entries.size();
    r   = $urandom_range(0, 99);
    val = pick_value();
    pos = POS_W'($urandom);
    if (r < 5) begin
      op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else if (r < 15) begin
      op = OP_DUMP;
    end else if (r < (fill_mode ? 75 : 45)) begin
      case ($urandom_range(0, 2))
        0: op = OP_INS_FRONT;
        1: op = OP_INS_BACK;
        default: op = OP_INS_POS;
      endcase
      if (op == OP_INS_POS && $urandom_range(0, 99) < 85) begin
        pos = POS_W'($urandom_range(1, len + 1));
      end
    end else begin
      op = OP_DELETE;
      if (len > 0 && $urandom_range(0, 99) < 75) begin
        val = list_entries[$urandom_range(0, len - 1)];
      end
    end
  endtask

  // Checks every beat the block shows against the oldest owed beat, field by field.
  always @(posedge clk) begin
    list_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, entry_value", out_entry_value, '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
        if (out_has_value !== want.has_value)
          report_mismatch("has_value", DATA_W'(out_has_value), DATA_W'(want.has_value));
        if (out_entry_value !== want.entry_value)
          report_mismatch("entry_value", out_entry_value, want.entry_value);
        if (out_length !== want.length)
          report_mismatch("length", DATA_W'(out_length), DATA_W'(want.length));
        if (out_last !== want.last)
          report_mismatch("last", DATA_W'(out_last), DATA_W'(want.last));
      end
    end
  end

  // Stimulus: reset once, walk the directed table, pause for the block to empty,
  // then random items in blocks of 40 that alternate between fill and drain
  // leaning, with every third block sent back to back. A second full pause falls
  // halfway through the random part.
  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    mismatch_count = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= '0;
    in_value     <= '0;
    in_position  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_item(dir_rows[r].op, dir_rows[r].value, dir_rows[r].position,
                  dir_rows[r].fixed, dir_rows[r].status, dir_rows[r].length);
        idle_gap(1'b0);
      end
    end
    drain_wait();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) drain_wait();
      pick_item(((i / 40) % 2) == 0, op, val, pos);
      send_item(op, val, pos, 1'b0, ST_OK, '0);
      idle_gap(((i / 40) % 3) == 2);
    end

    // Wait for every owed beat, then a little longer to catch stray beats.
    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLS) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
